[rtl/ddm_pkg.sv]
// Package: shared widths, register codes, reset values and control structs of the drive mixer.
`timescale 1ns / 1ps
package ddm_pkg;

  // Stream word widths (padded to whole bytes)
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // Configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegMaxFwd  = 2'd0;
  localparam logic [1:0] RegMaxRev  = 2'd1;
  localparam logic [1:0] RegTimeout = 2'd2;
  localparam logic [1:0] RegAlpha   = 2'd3;

  // Register reset values
  localparam logic [7:0]  MaxFwdRst  = 8'd200;
  localparam logic [7:0]  MaxRevRst  = 8'd60;
  localparam logic [15:0] TimeoutRst = 16'd200;
  localparam logic [15:0] AlphaRst   = 16'd9830;

  // Filter fraction bits default
  localparam int unsigned FracBitsDef = 8;

  // Percent limit and divide-by-100 reciprocal, exact for x < 43690
  localparam logic [6:0]  Pct100    = 7'd100;
  localparam logic [12:0] Div100Mul = 13'd5243;
  localparam int unsigned Div100Sh  = 19;

  typedef struct packed {
    logic [7:0]  max_fwd;
    logic [7:0]  max_rev;
    logic [15:0] timeout;
    logic [15:0] alpha;
  } cfg_t;

  // Step commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic div1;
    logic mul2;
    logic div2;
    logic fmul;
    logic fupd;
    logic sel_right;
    logic out_load;
  } cmd_t;

  // Divide a value below 25600 by 100, floor
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = x * Div100Mul;
    return p[Div100Sh +: 8];
  endfunction

endpackage

[rtl/ddm_cfg.sv]
// Module: configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ddm_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ddm_pkg::AddrW-1:0] paddr,
  input  logic [ddm_pkg::DataW-1:0] pwdata,
  output logic [ddm_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output ddm_pkg::cfg_t             cfg_o
);
  import ddm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegMaxFwd:  cfg_d.max_fwd = pwdata[7:0];
        RegMaxRev:  cfg_d.max_rev = pwdata[7:0];
        RegTimeout: cfg_d.timeout = pwdata[15:0];
        RegAlpha:   cfg_d.alpha   = pwdata[15:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_fwd <= MaxFwdRst;
      cfg_q.max_rev <= MaxRevRst;
      cfg_q.timeout <= TimeoutRst;
      cfg_q.alpha   <= AlphaRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      RegMaxFwd:  prdata = {24'd0, cfg_q.max_fwd};
      RegMaxRev:  prdata = {24'd0, cfg_q.max_rev};
      RegTimeout: prdata = {16'd0, cfg_q.timeout};
      RegAlpha:   prdata = {16'd0, cfg_q.alpha};
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/ddm_ctrl.sv]
// Module: sequencer that steps one word through the mixer datapath and owns the output valid.
`timescale 1ns / 1ps
module ddm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ddm_pkg::cmd_t cmd_o
);
  import ddm_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul1  = 4'd1;
  localparam logic [3:0] StDiv1  = 4'd2;
  localparam logic [3:0] StMul2  = 4'd3;
  localparam logic [3:0] StDiv2  = 4'd4;
  localparam logic [3:0] StFmulL = 4'd5;
  localparam logic [3:0] StFupdL = 4'd6;
  localparam logic [3:0] StFmulR = 4'd7;
  localparam logic [3:0] StFupdR = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_free    = !ovalid_q || out_ready_i;

  // Next state and step commands
  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = StMul1;
      end
      StMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d = StDiv1;
      end
      StDiv1: begin
        cmd_o.div1 = 1'b1;
        state_d = StMul2;
      end
      StMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d = StDiv2;
      end
      StDiv2: begin
        cmd_o.div2 = 1'b1;
        state_d = StFmulL;
      end
      StFmulL: begin
        cmd_o.fmul = 1'b1;
        state_d = StFupdL;
      end
      StFupdL: begin
        cmd_o.fupd = 1'b1;
        state_d = StFmulR;
      end
      StFmulR: begin
        cmd_o.fmul = 1'b1;
        cmd_o.sel_right = 1'b1;
        state_d = StFupdR;
      end
      StFupdR: begin
        cmd_o.fupd = 1'b1;
        cmd_o.sel_right = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

[rtl/ddm_dp.sv]
// Module: mixer datapath: failsafe, throttle map, steering mix, clamp, smoothing filter, split.
`timescale 1ns / 1ps
module ddm_dp #(
  parameter int unsigned FracBits = ddm_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ddm_pkg::cmd_t                cmd_i,
  input  ddm_pkg::cfg_t                cfg_i,
  input  logic [ddm_pkg::InDataW-1:0]  in_data_i,
  output logic [ddm_pkg::OutDataW-1:0] out_data_o
);
  import ddm_pkg::*;

  localparam int unsigned SW = FracBits + 10;  // smoothed state width
  localparam int unsigned PW = SW + 18;        // alpha * diff product width

  // Captured and intermediate registers
  logic signed [7:0]    thr_q, ste_q;
  logic                 ok_q;
  logic [14:0]          prod_q, prod_d;
  logic signed [9:0]    base_q;
  logic signed [9:0]    tgt_l_q, tgt_r_q;
  logic signed [SW-1:0] acc_l_q, acc_r_q, acc_upd;
  logic signed [PW-1:0] fprod_q;
  logic [OutDataW-1:0]  out_q;

  // Input unpack and saturate
  logic signed [7:0] in_thr, in_ste, thr_sat, ste_sat;
  logic              in_ok;

  function automatic logic signed [7:0] sat100(input logic signed [7:0] v);
    if (v > 8'sd100) return 8'sd100;
    if (v < -8'sd100) return -8'sd100;
    return v;
  endfunction

  assign in_thr  = in_data_i[7:0];
  assign in_ste  = in_data_i[15:8];
  assign in_ok   = in_data_i[16] && (in_data_i[32:17] < cfg_i.timeout);
  assign thr_sat = in_ok ? sat100(in_thr) : 8'sd0;
  assign ste_sat = in_ok ? sat100(in_ste) : 8'sd0;

  // Multiplier operands for the map and mix steps
  logic [6:0]        num1, ste_abs, fac;
  logic [7:0]        duty1, base_abs, q_div;
  logic              thr_neg;
  logic signed [9:0] inner, tl, tr;

  assign thr_neg  = thr_q[7];
  assign num1     = thr_neg ? 7'(thr_q + 8'sd100) : thr_q[6:0];
  assign duty1    = thr_neg ? cfg_i.max_rev : cfg_i.max_fwd;
  assign ste_abs  = ste_q[7] ? 7'(-ste_q) : ste_q[6:0];
  assign fac      = Pct100 - ste_abs;
  assign base_abs = base_q[9] ? 8'(-base_q) : base_q[7:0];
  assign q_div    = div100(prod_q);
  assign inner    = base_q[9] ? -$signed({2'b00, q_div}) : $signed({2'b00, q_div});

  always_comb begin
    prod_d = prod_q;
    if (cmd_i.mul1) prod_d = num1 * duty1;
    else if (cmd_i.mul2) prod_d = base_abs * fac;
  end

  // Inner wheel pick and clamp
  function automatic logic signed [9:0] clamp_wheel(input logic signed [9:0] v,
                                                    input logic [7:0] fwd,
                                                    input logic [7:0] rev);
    logic signed [10:0] neg_rev;
    neg_rev = -$signed({3'b000, rev});
    if (v > 10'sd0) begin
      return (v > $signed({2'b00, fwd})) ? $signed({2'b00, fwd}) : v;
    end
    return (11'(v) < neg_rev) ? 10'(neg_rev) : v;
  endfunction

  assign tl = (ste_q < 8'sd0) ? inner : base_q;
  assign tr = (ste_q > 8'sd0) ? inner : base_q;

  // Filter: shared multiplier and update for one wheel per step
  logic signed [9:0]    tgt_sel;
  logic signed [SW-1:0] acc_sel, scaled, scaled_abs, acc_abs, step;
  logic signed [SW:0]   diff;
  logic signed [PW-1:0] fprod_sh;

  assign tgt_sel    = cmd_i.sel_right ? tgt_r_q : tgt_l_q;
  assign acc_sel    = cmd_i.sel_right ? acc_r_q : acc_l_q;
  assign scaled     = $signed({{(SW-10){tgt_sel[9]}}, tgt_sel}) <<< FracBits;
  assign diff       = (SW+1)'(scaled) - (SW+1)'(acc_sel);
  assign scaled_abs = scaled[SW-1] ? -scaled : scaled;
  assign acc_abs    = acc_sel[SW-1] ? -acc_sel : acc_sel;
  assign fprod_sh   = fprod_q >>> 16;
  assign step       = fprod_sh[SW-1:0];
  assign acc_upd    = ($unsigned(scaled_abs) > $unsigned(acc_abs)) ? acc_sel + step : scaled;

  // Truncate toward zero and split into duties
  function automatic logic signed [8:0] trunc_val(input logic signed [SW-1:0] a);
    logic signed [SW-1:0] mag;
    mag = a[SW-1] ? -a : a;
    mag = mag >>> FracBits;
    return a[SW-1] ? -mag[8:0] : mag[8:0];
  endfunction

  logic signed [8:0] lv, rv;
  logic [7:0]        lf, lr, rf, rr;

  assign lv = ok_q ? trunc_val(acc_l_q) : 9'sd0;
  assign rv = ok_q ? trunc_val(acc_r_q) : 9'sd0;
  assign lf = (lv > 9'sd0) ? lv[7:0] : 8'd0;
  assign lr = (lv < 9'sd0) ? 8'(-lv) : 8'd0;
  assign rf = (rv > 9'sd0) ? rv[7:0] : 8'd0;
  assign rr = (rv < 9'sd0) ? 8'(-rv) : 8'd0;

  assign out_data_o = out_q;

  // Smoothing state, reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (cmd_i.fupd) begin
      if (cmd_i.sel_right) acc_r_q <= acc_upd;
      else acc_l_q <= acc_upd;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      thr_q <= thr_sat;
      ste_q <= ste_sat;
      ok_q  <= in_ok;
    end
    prod_q <= prod_d;
    if (cmd_i.div1) begin
      base_q <= thr_neg ? $signed({2'b00, q_div}) - $signed({2'b00, cfg_i.max_rev})
                        : $signed({2'b00, q_div});
    end
    if (cmd_i.div2) begin
      tgt_l_q <= clamp_wheel(tl, cfg_i.max_fwd, cfg_i.max_rev);
      tgt_r_q <= clamp_wheel(tr, cfg_i.max_fwd, cfg_i.max_rev);
    end
    if (cmd_i.fmul) fprod_q <= $signed({1'b0, cfg_i.alpha}) * diff;
    if (cmd_i.out_load) out_q <= {7'd0, ok_q, rr, rf, lr, lf};
  end

endmodule

[rtl/differential_drive_mixer.sv]
// Top level: differential drive mixer with failsafe and acceleration smoothing.
//
//  Port group   Dir  Contents
//  s_axis_*     in   throttle, steering, client_connected, message_age_ms
//  m_axis_*     out  four wheel duties and link_ok
//  APB (p*)     in   max_forward_duty, max_reverse_duty, link_timeout_ms, accel_alpha
//
// A word passes from acceptance to the output register through a fixed
// sequence of map multiply, divide-by-100, mix multiply, divide, then one
// shared filter multiplier and update per wheel, then the output load.
// The input is ready again in the cycle after the load. One word is in
// work at a time; a stalled output holds the last step only. Reset is
// asynchronous, active low; it restores register defaults and clears
// both smoothing accumulators.
`timescale 1ns / 1ps
module differential_drive_mixer #(
  parameter int unsigned SMOOTH_FRACTION_BITS = ddm_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // [7:0] throttle, [15:8] steering, [16] client_connected, [32:17] message_age_ms
  input  logic [ddm_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [7:0] left_fwd, [15:8] left_rev, [23:16] right_fwd, [31:24] right_rev, [32] link_ok
  output logic [ddm_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ddm_pkg::AddrW-1:0]    paddr,
  input  logic [ddm_pkg::DataW-1:0]    pwdata,
  output logic [ddm_pkg::DataW-1:0]    prdata,
  output logic                         pready
);
  import ddm_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  ddm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ddm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ddm_dp #(
    .FracBits (SMOOTH_FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

[bench/tb_top.sv]
// Testbench: drives the drive mixer with steering and throttle words and checks every duty word.
`timescale 1ns / 1ps
module tb_top;
  import ddm_pkg::*;

  localparam int FracBits = FracBitsDef;

  // One control tick as it travels on the input stream
  typedef struct packed {
    logic signed [7:0] throttle;
    logic signed [7:0] steering;
    logic              connected;
    logic [15:0]       age_ms;
  } mix_cmd_t;

  // One expected output word
  typedef struct packed {
    logic [7:0] left_fwd;
    logic [7:0] left_rev;
    logic [7:0] right_fwd;
    logic [7:0] right_rev;
    logic       link_ok;
  } wheel_duty_t;

  // Mixer predictor with its own register copy and smoothing state
  class duty_scoreboard;
    localparam int Pct = 100;

    logic [7:0]  max_fwd;
    logic [7:0]  max_rev;
    logic [15:0] timeout;
    logic [15:0] alpha;
    int          left_acc;
    int          right_acc;
    wheel_duty_t duty_q[$];
    int          errors;

    function new();
      max_fwd   = MaxFwdRst;
      max_rev   = MaxRevRst;
      timeout   = TimeoutRst;
      alpha     = AlphaRst;
      left_acc  = 0;
      right_acc = 0;
      errors    = 0;
    endfunction

    function int pending();
      return duty_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegMaxFwd:  max_fwd = val[7:0];
        RegMaxRev:  max_rev = val[7:0];
        RegTimeout: timeout = val[15:0];
        RegAlpha:   alpha   = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        RegMaxFwd:  return {24'd0, max_fwd};
        RegMaxRev:  return {24'd0, max_rev};
        RegTimeout: return {16'd0, timeout};
        default:    return {16'd0, alpha};
      endcase
    endfunction

    function int clip_pct(logic signed [7:0] v);
      if (v > Pct) return Pct;
      if (v < -Pct) return -Pct;
      return int'(v);
    endfunction

    function int clamp_duty(int v);
      if (v > 0) return (v > int'(max_fwd)) ? int'(max_fwd) : v;
      return (v < -int'(max_rev)) ? -int'(max_rev) : v;
    endfunction

    // Rising magnitude moves by alpha toward the target, anything else snaps
    function int filter_wheel(bit right_side, int target);
      int     acc;
      int     scaled;
      longint step;
      acc    = right_side ? right_acc : left_acc;
      scaled = target * (1 << FracBits);
      if ((scaled < 0 ? -scaled : scaled) > (acc < 0 ? -acc : acc)) begin
        step = longint'(alpha) * (longint'(scaled) - longint'(acc));
        acc  = acc + int'(step >>> 16);
      end else begin
        acc = scaled;
      end
      if (right_side) right_acc = acc;
      else left_acc = acc;
      return (acc >= 0) ? (acc >>> FracBits) : -((-acc) >>> FracBits);
    endfunction

    function void note_input(mix_cmd_t c);
      int          thr;
      int          ste;
      int          base;
      int          lw;
      int          rw;
      int          lv;
      int          rv;
      bit          ok;
      wheel_duty_t d;
      thr = clip_pct(c.throttle);
      ste = clip_pct(c.steering);
      ok  = c.connected && (c.age_ms < timeout);
      if (!ok) begin
        thr = 0;
        ste = 0;
      end
      // throttle map, floor of non-negative quotients
      if (thr >= 0) base = thr * int'(max_fwd) / Pct;
      else base = (thr + Pct) * int'(max_rev) / Pct - int'(max_rev);
      // inner wheel slows down, quotient truncates toward zero
      lw = base;
      rw = base;
      if (ste > 0) rw = base * (Pct - ste) / Pct;
      else if (ste < 0) lw = base * (Pct + ste) / Pct;
      lv = filter_wheel(1'b0, clamp_duty(lw));
      rv = filter_wheel(1'b1, clamp_duty(rw));
      if (!ok) begin
        lv = 0;
        rv = 0;
      end
      d.left_fwd  = (lv > 0) ? 8'(lv) : 8'd0;
      d.left_rev  = (lv < 0) ? 8'(-lv) : 8'd0;
      d.right_fwd = (rv > 0) ? 8'(rv) : 8'd0;
      d.right_rev = (rv < 0) ? 8'(-rv) : 8'd0;
      d.link_ok   = ok;
      duty_q.push_back(d);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(logic [OutDataW-1:0] word);
      wheel_duty_t want;
      if (duty_q.size() == 0) begin
        report_mismatch("output word with nothing expected");
        return;
      end
      want = duty_q.pop_front();
      check_field("left_forward_duty", word[7:0], want.left_fwd);
      check_field("left_reverse_duty", word[15:8], want.left_rev);
      check_field("right_forward_duty", word[23:16], want.right_fwd);
      check_field("right_reverse_duty", word[31:24], want.right_rev);
      check_field("link_ok", {7'd0, word[32]}, {7'd0, want.link_ok});
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  // [7:0] throttle, [15:8] steering, [16] client_connected, [32:17] message_age_ms
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [7:0] left_fwd, [15:8] left_rev, [23:16] right_fwd, [31:24] right_rev, [32] link_ok
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  duty_scoreboard sb = new();
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  quiet = 1'b0;

  differential_drive_mixer #(.SMOOTH_FRACTION_BITS(FracBits)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Output side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= quiet || ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic mix_cmd_t cmd_of(logic signed [7:0] thr, logic signed [7:0] ste,
                                      logic conn, logic [15:0] age);
    mix_cmd_t c;
    c.throttle  = thr;
    c.steering  = ste;
    c.connected = conn;
    c.age_ms    = age;
    return c;
  endfunction

  // Mostly in-range percents and live ages, some full-range noise
  function automatic mix_cmd_t random_cmd();
    mix_cmd_t    c;
    logic [15:0] to;
    to = sb.timeout;
    c.throttle  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'(int'($urandom_range(200)) - 100);
    c.steering  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'(int'($urandom_range(200)) - 100);
    c.connected = ($urandom_range(7) != 0);
    case ($urandom_range(5))
      0:       c.age_ms = 16'($urandom);
      1:       c.age_ms = to - 16'($urandom_range(1));
      default: c.age_ms = (to == 0) ? 16'($urandom) : 16'($urandom_range(int'(to) - 1));
    endcase
    return c;
  endfunction

  task automatic send_cmd(input mix_cmd_t c);
    while (!quiet && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, c.age_ms, c.connected, c.steering, c.throttle};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(c);
  endtask

  // Hold the input until every expected word has come out
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // APB write followed by a read-back
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== sb.reg_value(idx))
      sb.report_mismatch($sformatf("register %0d read %0h want %0h", idx, prdata,
                                   sb.reg_value(idx)));
    psel    <= 1'b0;
    penable <= 1'b0;
    // bus idle before the next transfer
    @(posedge clk_i);
  endtask

  // One setting of the registers, then runs of repeated ticks with noise
  task automatic run_phase(input logic [7:0] fwd, input logic [7:0] rev,
                           input logic [15:0] to, input logic [15:0] alp,
                           input int tx_pct, input int rx_pct, input int count);
    mix_cmd_t c;
    int       sent;
    int       run_len;
    wait_results();
    reg_write(RegMaxFwd, {24'd0, fwd});
    reg_write(RegMaxRev, {24'd0, rev});
    reg_write(RegTimeout, {16'd0, to});
    reg_write(RegAlpha, {16'd0, alp});
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      c       = random_cmd();
      run_len = $urandom_range(1, 12);
      quiet   = ($urandom_range(3) == 0);
      for (int k = 0; k < run_len && sent < count; k++) begin
        if ($urandom_range(9) == 0) c = random_cmd();
        send_cmd(c);
        sent++;
        if (sent == count / 2 || $urandom_range(63) == 0) wait_results();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at the reset settings
    send_cmd(cmd_of(8'sd100, 8'sd0, 1'b1, 16'd0));
    send_cmd(cmd_of(8'sd100, 8'sd0, 1'b1, 16'd0));
    send_cmd(cmd_of(8'sd127, 8'sd0, 1'b1, 16'd10));
    send_cmd(cmd_of(8'sd127, 8'sd127, 1'b1, 16'd10));
    send_cmd(cmd_of(8'sd50, 8'sd60, 1'b1, 16'd50));
    send_cmd(cmd_of(8'sd50, -8'sd60, 1'b1, 16'd50));
    send_cmd(cmd_of(8'sd0, 8'sd0, 1'b1, 16'd0));
    send_cmd(cmd_of(-8'sd100, 8'sd0, 1'b1, 16'd0));
    send_cmd(cmd_of(-8'sd100, 8'sd100, 1'b1, 16'd0));
    send_cmd(cmd_of(-8'sd100, -8'sd100, 1'b1, 16'd0));
    send_cmd(cmd_of(8'sh80, 8'sh80, 1'b1, 16'd1));
    send_cmd(cmd_of(-8'sd1, 8'sd1, 1'b1, 16'd199));
    send_cmd(cmd_of(8'sd100, 8'sd0, 1'b1, 16'd199));
    // failsafe: stale age, saturated age, no client
    send_cmd(cmd_of(8'sd100, 8'sd0, 1'b1, 16'd200));
    send_cmd(cmd_of(8'sd100, 8'sd0, 1'b1, 16'hffff));
    send_cmd(cmd_of(8'sd100, -8'sd30, 1'b0, 16'd0));
    send_cmd(cmd_of(8'sd99, 8'sd99, 1'b1, 16'd100));
    send_cmd(cmd_of(8'sd101, -8'sd101, 1'b1, 16'd100));

    // Extremes, zero timeout, zero alpha, and back to the reset values
    run_phase(8'd255, 8'd255, 16'hffff, 16'hffff, 0, 0, 90);
    run_phase(8'd0, 8'd0, 16'd1, 16'd0, 53, 0, 40);
    run_phase(8'd180, 8'd90, 16'd1000, 16'd20000, 0, 53, 90);
    run_phase(8'd100, 8'd200, 16'd0, 16'd30000, 17, 17, 30);
    run_phase(8'd220, 8'd40, 16'd500, 16'd3000, 53, 0, 90);
    run_phase(8'd255, 8'd255, 16'hffff, 16'd9830, 17, 17, 90);
    run_phase(8'd150, 8'd150, 16'd300, 16'd0, 0, 53, 40);
    run_phase(MaxFwdRst, MaxRevRst, TimeoutRst, AlphaRst, 17, 17, 120);

    wait_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ddm_pkg.sv
rtl/ddm_cfg.sv
rtl/ddm_ctrl.sv
rtl/ddm_dp.sv
rtl/differential_drive_mixer.sv
bench/tb_top.sv
